// File: design/mqpt_pkg.sv
// Shared types and constants for the match queue pairing table.
// No dependencies; imported by every module of the block.
package mqpt_pkg;

    localparam logic [1:0]  OP_JOIN  = 2'd0;
    localparam logic [1:0]  OP_LEAVE = 2'd1;
    localparam logic [1:0]  OP_PURGE = 2'd2;

    localparam logic [12:0] MIN_JOIN_PAYLOAD = 13'd11;
    localparam logic [15:0] TOLERANCE_RESET  = 16'd200;

    typedef enum logic [2:0] {
        ST_QUEUED  = 3'd0,
        ST_MATCHED = 3'd1,
        ST_FULL    = 3'd2,
        ST_REMOVED = 3'd3,
        ST_NONE    = 3'd4,
        ST_SHORT   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CMD_JOIN,
        CMD_LEAVE,
        CMD_PURGE,
        CMD_SHORT,
        CMD_NONE
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] client;
        logic [31:0] character;
        logic [7:0]  kind;
        logic [15:0] rating;
        logic [31:0] key;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] match_number;
        logic [31:0] partner_client;
        logic [31:0] partner_character;
        logic [15:0] partner_rating;
    } t_res;

endpackage

// File: design/mqpt_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
// Depends on mqpt_pkg.
module mqpt_front
    import mqpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_client_id,
    input  logic [31:0] i_character_number,
    input  logic [7:0]  i_match_kind,
    input  logic [15:0] i_skill_rating,
    input  logic [31:0] i_queue_key,
    input  logic [12:0] i_payload_length,
    output logic        o_q_valid,
    output t_req        o_q_req,
    input  logic        i_q_pop
);

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_req       w_req;
    logic       w_push;

    always_comb begin
        w_req.client    = i_client_id;
        w_req.character = i_character_number;
        w_req.kind      = i_match_kind;
        w_req.rating    = i_skill_rating;
        w_req.key       = i_queue_key;
        unique case (i_opcode)
            OP_JOIN:  w_req.cmd = (i_payload_length < MIN_JOIN_PAYLOAD) ? CMD_SHORT : CMD_JOIN;
            OP_LEAVE: w_req.cmd = CMD_LEAVE;
            OP_PURGE: w_req.cmd = CMD_PURGE;
            default:  w_req.cmd = CMD_NONE;
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

// File: design/mqpt_back.sv
// Back end: table memory, valid bits and the sequential scan engine.
// Depends on mqpt_pkg; fed by mqpt_front.
module mqpt_back
    import mqpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_tolerance,
    input  logic        i_q_valid,
    input  t_req        i_q_req,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_res        o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic [31:0] client;
        logic [31:0] character;
        logic [7:0]  kind;
        logic [15:0] rating;
        logic [31:0] key;
    } t_entry;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_entry          r_mem [QUEUE_DEPTH];
    logic            r_valid [QUEUE_DEPTH];
    t_state          r_state;
    t_req            r_req;
    logic [AW-1:0]   r_addr;
    logic            r_issue;
    logic [AW-1:0]   r_rd_idx;
    logic            r_rd_live;
    t_entry          r_rd_data;
    logic            r_free_found;
    logic [AW-1:0]   r_free_idx;
    logic            r_hit_found;
    logic [AW-1:0]   r_hit_idx;
    t_entry          r_hit;
    logic [31:0]     r_next;
    logic            r_out_valid;
    t_res            r_res;
    logic            w_e_valid;
    logic            w_same_client;
    logic [15:0]     w_diff;
    logic            w_join_hit;
    logic            w_leave_done;
    logic            w_wr;
    t_entry          w_new;

    assign w_e_valid     = r_valid[r_rd_idx];
    assign w_same_client = (r_rd_data.client == r_req.client);
    assign w_diff        = (r_rd_data.rating >= r_req.rating) ?
                           (r_rd_data.rating - r_req.rating) : (r_req.rating - r_rd_data.rating);
    assign w_join_hit    = w_e_valid && !w_same_client && (r_rd_data.kind == r_req.kind)
                           && (r_rd_data.key == r_req.key) && (w_diff <= i_tolerance);
    assign w_leave_done  = r_rd_live && (r_req.cmd == CMD_LEAVE) && w_e_valid && w_same_client;
    assign o_q_pop       = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
    assign o_valid       = r_out_valid;
    assign o_res         = r_res;
    assign w_wr          = (r_state == S_FIN) && (r_req.cmd == CMD_JOIN) && r_free_found
                           && !r_hit_found;

    always_comb begin
        w_new.client    = r_req.client;
        w_new.character = r_req.character;
        w_new.kind      = r_req.kind;
        w_new.rating    = r_req.rating;
        w_new.key       = r_req.key;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_free_idx] <= w_new;
        end
        if ((r_state == S_SCAN) && r_issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_next      <= 32'd1;
            r_issue     <= 1'b0;
            r_rd_live   <= 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_req <= i_q_req;
                        r_res <= '{status: ((i_q_req.cmd == CMD_SHORT) ? ST_SHORT : ST_NONE),
                                   default: '0};
                        if ((i_q_req.cmd == CMD_SHORT) || (i_q_req.cmd == CMD_NONE)) begin
                            r_out_valid <= 1'b1;
                        end else begin
                            r_addr       <= '0;
                            r_issue      <= 1'b1;
                            r_rd_live    <= 1'b0;
                            r_free_found <= 1'b0;
                            r_hit_found  <= 1'b0;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_live <= r_issue;
                    if (r_issue) begin
                        r_rd_idx <= r_addr;
                        if ((r_addr == LAST) || w_leave_done) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_rd_live) begin
                        if ((r_rd_idx == LAST) || w_leave_done) begin
                            r_state <= S_FIN;
                        end
                        if (r_req.cmd == CMD_JOIN) begin
                            if (!w_e_valid && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_rd_idx;
                            end
                            if (w_join_hit && !r_hit_found) begin
                                r_hit_found <= 1'b1;
                                r_hit_idx   <= r_rd_idx;
                                r_hit       <= r_rd_data;
                            end
                        end else if (w_e_valid && w_same_client) begin
                            r_valid[r_rd_idx] <= 1'b0;
                            r_hit_found       <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    r_out_valid <= 1'b1;
                    r_rd_live   <= 1'b0;
                    r_state     <= S_IDLE;
                    if (r_req.cmd == CMD_JOIN) begin
                        if (!r_free_found) begin
                            r_res.status <= ST_FULL;
                        end else if (r_hit_found) begin
                            r_valid[r_hit_idx]      <= 1'b0;
                            r_res.status            <= ST_MATCHED;
                            r_res.match_number      <= r_next;
                            r_res.partner_client    <= r_hit.client;
                            r_res.partner_character <= r_hit.character;
                            r_res.partner_rating    <= r_hit.rating;
                            r_next                  <= r_next + 32'd1;
                        end else begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_res.status        <= ST_QUEUED;
                        end
                    end else begin
                        r_res.status <= r_hit_found ? ST_REMOVED : ST_NONE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/match_queue_pairing_table.sv
// Top level of the match queue pairing table: tolerance register, front and back.
// Depends on mqpt_pkg, mqpt_front and mqpt_back.
// A join or purge takes one pass over the table memory, one slot read per cycle;
// a leave stops at the client's first entry and so ends its scan early when it
// finds one; a short-payload join or an unused opcode answers without a scan.
// Items wait in a two-entry queue while a scan runs; the back end takes no new
// item while a result waits to be taken.
module match_queue_pairing_table
    import mqpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_client_id,
    input  logic [31:0] i_character_number,
    input  logic [7:0]  i_match_kind,
    input  logic [15:0] i_skill_rating,
    input  logic [31:0] i_queue_key,
    input  logic [12:0] i_payload_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_match_number,
    output logic [31:0] o_partner_client,
    output logic [31:0] o_partner_character,
    output logic [15:0] o_partner_rating
);

    logic [15:0] r_tolerance;
    logic        w_q_valid;
    t_req        w_q_req;
    logic        w_q_pop;
    t_res        w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOLERANCE_RESET;
        end else if (i_cfg_we) begin
            r_tolerance <= i_cfg_data;
        end
    end

    mqpt_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_opcode           (i_opcode),
        .i_client_id        (i_client_id),
        .i_character_number (i_character_number),
        .i_match_kind       (i_match_kind),
        .i_skill_rating     (i_skill_rating),
        .i_queue_key        (i_queue_key),
        .i_payload_length   (i_payload_length),
        .o_q_valid          (w_q_valid),
        .o_q_req            (w_q_req),
        .i_q_pop            (w_q_pop)
    );

    mqpt_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tolerance (r_tolerance),
        .i_q_valid   (w_q_valid),
        .i_q_req     (w_q_req),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_res       (w_res)
    );

    assign o_status            = w_res.status;
    assign o_match_number      = w_res.match_number;
    assign o_partner_client    = w_res.partner_client;
    assign o_partner_character = w_res.partner_character;
    assign o_partner_rating    = w_res.partner_rating;

    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (w_res.status != ST_MATCHED) |->
        (o_match_number == 32'd0) && (o_partner_client == 32'd0) &&
        (o_partner_character == 32'd0) && (o_partner_rating == 16'd0))
        else $error("unmatched result carries partner data");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid && !o_out_valid)
        else $error("queue popped while empty or result pending");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_out_valid) |-> !$past(i_out_stall))
        else $error("result dropped while stalled");

endmodule
